// ----- rtl/core/pcm_pkg.sv -----
// pcm_pkg: shared types and constants for the pairwise cluster metrics block.
// No dependencies.
package pcm_pkg;

  localparam int LBL_W   = 6;
  localparam int CFG_W   = 7;
  localparam int Q_W     = 17;
  localparam int FRAC_W  = 16;
  localparam int PAIR_W  = 15;
  localparam int FLAG_W  = 3;
  localparam int CFG_IDX_W = 1;

  localparam int DEF_MAX_SAMPLES = 256;
  localparam int DEF_MAX_LABELS  = 64;

  localparam logic [Q_W-1:0] Q_ONE = 17'h10000;

  localparam logic [CFG_IDX_W-1:0] REG_TRUE_CNT = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_PRED_CNT = 1'b1;

  localparam logic [1:0] RSEL_RAND = 2'd0;
  localparam logic [1:0] RSEL_PREC = 2'd1;
  localparam logic [1:0] RSEL_REC  = 2'd2;

  typedef enum logic [2:0] {
    S_SWEEP,
    S_IDLE,
    S_RUN,
    S_DIV,
    S_OUT
  } state_t;

  typedef struct packed {
    logic [LBL_W-1:0] true_label;
    logic [LBL_W-1:0] pred_label;
    logic             last_sample;
  } sample_t;

  typedef struct packed {
    logic [Q_W-1:0]    rand_index;
    logic [Q_W-1:0]    precision;
    logic [Q_W-1:0]    recall;
    logic [PAIR_W-1:0] agree_same_pairs;
    logic [PAIR_W-1:0] agree_diff_pairs;
    logic [FLAG_W-1:0] zero_divisor_flags;
  } result_t;

  typedef struct packed {
    logic             vld;
    logic [LBL_W-1:0] tl;
    logic [LBL_W-1:0] pl;
  } query_t;

  typedef struct packed {
    logic same;
    logic diff;
    logic settle;
  } cell_stat_t;

endpackage

// ----- rtl/core/pcm_cell.sv -----
// pcm_cell: one stored sample slot of the comparison chain.
// Depends on pcm_pkg.
module pcm_cell (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                clr,
  input  pcm_pkg::query_t     q_in,
  output pcm_pkg::query_t     q_out,
  output pcm_pkg::cell_stat_t stat
);

  logic                     valid_r;
  logic [pcm_pkg::LBL_W-1:0] tl_r;
  logic [pcm_pkg::LBL_W-1:0] pl_r;
  logic                     qv_r;
  logic [pcm_pkg::LBL_W-1:0] qtl_r;
  logic [pcm_pkg::LBL_W-1:0] qpl_r;
  logic                     hit;
  logic                     settle;
  logic                     st;
  logic                     sp;

  assign hit    = qv_r & valid_r;
  assign settle = qv_r & ~valid_r;
  assign st     = (tl_r == qtl_r);
  assign sp     = (pl_r == qpl_r);

  always_ff @(posedge clk) begin
    if (!rst_n || clr) begin
      valid_r <= 1'b0;
      qv_r    <= 1'b0;
    end else begin
      qv_r <= q_in.vld;
      if (settle) begin
        valid_r <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    qtl_r <= q_in.tl;
    qpl_r <= q_in.pl;
    if (settle) begin
      tl_r <= qtl_r;
      pl_r <= qpl_r;
    end
  end

  assign q_out = '{vld: hit, tl: qtl_r, pl: qpl_r};
  assign stat  = '{same: hit & st & sp, diff: hit & ~st & ~sp, settle: settle};

endmodule

// ----- rtl/core/pcm_div.sv -----
// pcm_div: Q1.16 ratio unit, one quotient bit per cycle, saturating at 1.0.
// Depends on pcm_pkg.
module pcm_div #(
  parameter int NW = 18
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      start,
  input  logic [NW-1:0]             num,
  input  logic [NW-1:0]             den,
  output logic                      done,
  output logic [pcm_pkg::Q_W-1:0]   quo,
  output logic                      zero
);

  localparam int CNT_W = $clog2(pcm_pkg::FRAC_W + 1);

  logic               busy_r;
  logic [CNT_W-1:0]   cnt_r;
  logic [NW-1:0]      rem_r;
  logic [NW-1:0]      den_r;
  logic [pcm_pkg::Q_W-1:0] q_r;
  logic               done_r;
  logic               zero_r;
  logic [NW:0]        rem2;
  logic               ge;

  assign rem2 = {rem_r, 1'b0};
  assign ge   = (rem2 >= {1'b0, den_r});

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        den_r  <= den;
        zero_r <= (den == '0);
        if (den == '0) begin
          q_r    <= '0;
          done_r <= 1'b1;
        end else if (num >= den) begin
          q_r    <= pcm_pkg::Q_ONE;
          done_r <= 1'b1;
        end else begin
          q_r    <= '0;
          rem_r  <= num;
          cnt_r  <= CNT_W'(pcm_pkg::FRAC_W);
          busy_r <= 1'b1;
        end
      end else if (busy_r) begin
        rem_r <= ge ? NW'(rem2 - {1'b0, den_r}) : NW'(rem2);
        q_r   <= {q_r[pcm_pkg::Q_W-2:0], ge};
        cnt_r <= cnt_r - CNT_W'(1);
        if (cnt_r == CNT_W'(1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  assign done = done_r;
  assign quo  = q_r;
  assign zero = zero_r;

endmodule

// ----- rtl/core/pairwise_cluster_metrics.sv -----
// pairwise_cluster_metrics: top level, cell chain, label histograms, ratio sequencing.
// Depends on pcm_pkg, pcm_cell, pcm_div.
//
//  channel | ports                      | transaction
//  input   | start, busy, in_sample     | start high while busy low
//  result  | out_valid, out_result      | one-cycle strobe, no back-pressure
//  config  | cfg_we, cfg_index, cfg_data| write when cfg_we high
//
// A sample walks the cell chain to the first empty cell. A last sample adds a histogram
// sweep, three ratio divisions in the shared divider, and an output state. After reset
// the block is busy while it clears the histogram memories. The result cannot be stalled.
module pairwise_cluster_metrics #(
  parameter int MAX_SAMPLES = pcm_pkg::DEF_MAX_SAMPLES,
  parameter int MAX_LABELS  = pcm_pkg::DEF_MAX_LABELS
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  output logic                          busy,
  input  pcm_pkg::sample_t              in_sample,
  output logic                          out_valid,
  output pcm_pkg::result_t              out_result,
  input  logic                          cfg_we,
  input  logic [pcm_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [pcm_pkg::CFG_W-1:0]     cfg_data
);

  localparam int CW = $clog2(MAX_SAMPLES + 1);
  localparam int PW = 2 * CW;
  localparam int LW = $clog2(MAX_LABELS);
  localparam int SW = $clog2(MAX_LABELS + 2);

  pcm_pkg::state_t state_r, state_nxt;

  logic [pcm_pkg::CFG_W-1:0] tcc_r, pcc_r;
  logic [CW-1:0] n_r;
  logic [PW-1:0] tp_r, tn_r;
  logic          last_r, eval_r;
  logic [SW-1:0] cnt_r;
  logic          accept, room, inject;

  pcm_pkg::query_t     q_chain [MAX_SAMPLES];
  pcm_pkg::query_t     q_tail;
  pcm_pkg::cell_stat_t cst [MAX_SAMPLES];
  logic [MAX_SAMPLES-1:0] same_v, diff_v, settle_v;
  logic same_any, diff_any, settle_any;
  logic clr_cells;

  assign busy   = (state_r != pcm_pkg::S_IDLE);
  assign accept = start & ~busy;
  assign room   = (n_r < CW'(MAX_SAMPLES));
  assign inject = accept & room;
  assign clr_cells = (state_r == pcm_pkg::S_OUT);

  assign q_chain[0] = '{vld: inject, tl: in_sample.true_label, pl: in_sample.pred_label};

  for (genvar g = 0; g < MAX_SAMPLES; g++) begin : g_cell
    if (g == MAX_SAMPLES - 1) begin : g_end
      pcm_cell u_cell (
        .clk(clk), .rst_n(rst_n), .clr(clr_cells),
        .q_in(q_chain[g]), .q_out(q_tail), .stat(cst[g])
      );
    end else begin : g_mid
      pcm_cell u_cell (
        .clk(clk), .rst_n(rst_n), .clr(clr_cells),
        .q_in(q_chain[g]), .q_out(q_chain[g+1]), .stat(cst[g])
      );
    end
  end

  always_comb begin
    for (int i = 0; i < MAX_SAMPLES; i++) begin
      same_v[i]   = cst[i].same;
      diff_v[i]   = cst[i].diff;
      settle_v[i] = cst[i].settle;
    end
  end

  assign same_any   = |same_v;
  assign diff_any   = |diff_v;
  assign settle_any = |settle_v;

  // configuration
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tcc_r <= '0;
      pcc_r <= '0;
    end else if (cfg_we) begin
      if (cfg_index == pcm_pkg::REG_TRUE_CNT) tcc_r <= cfg_data;
      if (cfg_index == pcm_pkg::REG_PRED_CNT) pcc_r <= cfg_data;
    end
  end

  // divider handshake
  logic [1:0]              sel_r;
  logic                    issued_r;
  logic                    div_start, div_done, div_zero;
  logic [pcm_pkg::Q_W-1:0] div_quo;
  logic [PW-1:0]           div_num, div_den;
  logic [PW-1:0]           apair_r, tsum_r, psum_r;

  assign div_start = (state_r == pcm_pkg::S_DIV) && !issued_r;

  always_comb begin
    unique case (sel_r)
      pcm_pkg::RSEL_RAND: begin div_num = PW'(tp_r + tn_r); div_den = apair_r; end
      pcm_pkg::RSEL_PREC: begin div_num = tp_r; div_den = psum_r; end
      pcm_pkg::RSEL_REC:  begin div_num = tp_r; div_den = tsum_r; end
      default:            begin div_num = '0; div_den = '0; end
    endcase
  end

  pcm_div #(.NW(PW)) u_div (
    .clk(clk), .rst_n(rst_n), .start(div_start), .num(div_num), .den(div_den),
    .done(div_done), .quo(div_quo), .zero(div_zero)
  );

  // state machine
  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= pcm_pkg::S_SWEEP;
    else        state_r <= state_nxt;
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      pcm_pkg::S_SWEEP: begin
        if (cnt_r == SW'(MAX_LABELS + 1)) state_nxt = eval_r ? pcm_pkg::S_DIV : pcm_pkg::S_IDLE;
      end
      pcm_pkg::S_IDLE: begin
        if (accept) begin
          if (room)                       state_nxt = pcm_pkg::S_RUN;
          else if (in_sample.last_sample) state_nxt = pcm_pkg::S_SWEEP;
        end
      end
      pcm_pkg::S_RUN: begin
        if (settle_any) state_nxt = last_r ? pcm_pkg::S_SWEEP : pcm_pkg::S_IDLE;
      end
      pcm_pkg::S_DIV: begin
        if (div_done && sel_r == pcm_pkg::RSEL_REC) state_nxt = pcm_pkg::S_OUT;
      end
      pcm_pkg::S_OUT: state_nxt = pcm_pkg::S_IDLE;
      default:        state_nxt = pcm_pkg::S_IDLE;
    endcase
  end

  logic sweep_on;
  logic sweep_rw;
  assign sweep_on = (state_r == pcm_pkg::S_SWEEP);
  assign sweep_rw = sweep_on && (cnt_r < SW'(MAX_LABELS));

  // control counters
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      eval_r   <= 1'b0;
      cnt_r    <= '0;
      n_r      <= '0;
      tp_r     <= '0;
      tn_r     <= '0;
      sel_r    <= pcm_pkg::RSEL_RAND;
      issued_r <= 1'b0;
      last_r   <= 1'b0;
    end else begin
      cnt_r <= sweep_on ? cnt_r + SW'(1) : '0;
      if (!sweep_on && state_nxt == pcm_pkg::S_SWEEP) eval_r <= 1'b1;
      else if (state_r == pcm_pkg::S_DIV)             eval_r <= 1'b0;
      if (accept) last_r <= in_sample.last_sample;
      if (state_r == pcm_pkg::S_OUT) begin
        n_r  <= '0;
        tp_r <= '0;
        tn_r <= '0;
      end else begin
        if (inject) n_r <= n_r + CW'(1);
        if (state_r == pcm_pkg::S_RUN) begin
          tp_r <= tp_r + PW'(same_any);
          tn_r <= tn_r + PW'(diff_any);
        end
      end
      if (state_r != pcm_pkg::S_DIV) begin
        sel_r    <= pcm_pkg::RSEL_RAND;
        issued_r <= 1'b0;
      end else if (div_done) begin
        sel_r    <= sel_r + 2'd1;
        issued_r <= 1'b0;
      end else if (div_start) begin
        issued_r <= 1'b1;
      end
    end
  end

  // label histograms
  logic [CW-1:0] th_mem [MAX_LABELS];
  logic [CW-1:0] ph_mem [MAX_LABELS];
  logic [CW-1:0] th_rd_r, ph_rd_r;
  logic [LW-1:0] tla_r, pla_r, th_ra, ph_ra;
  logic          upd_r, tok_r, pok_r;
  logic          th_we, ph_we;
  logic [LW-1:0] th_wa, ph_wa;
  logic [CW-1:0] th_wd, ph_wd;

  assign th_ra = sweep_on ? LW'(cnt_r) : LW'(in_sample.true_label);
  assign ph_ra = sweep_on ? LW'(cnt_r) : LW'(in_sample.pred_label);
  assign th_we = sweep_rw || (upd_r && tok_r);
  assign ph_we = sweep_rw || (upd_r && pok_r);
  assign th_wa = sweep_on ? LW'(cnt_r) : tla_r;
  assign ph_wa = sweep_on ? LW'(cnt_r) : pla_r;
  assign th_wd = sweep_on ? '0 : th_rd_r + CW'(1);
  assign ph_wd = sweep_on ? '0 : ph_rd_r + CW'(1);

  always_ff @(posedge clk) begin
    if (th_we) th_mem[th_wa] <= th_wd;
    th_rd_r <= th_mem[th_ra];
  end

  always_ff @(posedge clk) begin
    if (ph_we) ph_mem[ph_wa] <= ph_wd;
    ph_rd_r <= ph_mem[ph_ra];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) upd_r <= 1'b0;
    else        upd_r <= inject;
  end

  always_ff @(posedge clk) begin
    if (inject) begin
      tla_r <= LW'(in_sample.true_label);
      pla_r <= LW'(in_sample.pred_label);
      tok_r <= (32'(in_sample.true_label) < MAX_LABELS);
      pok_r <= (32'(in_sample.pred_label) < MAX_LABELS);
    end
  end

  // pair sums over the sweep
  logic          s1_vld_r, s1_tin_r, s1_pin_r;
  logic [PW-1:0] tprod_r, pprod_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r <= 1'b0;
    end else begin
      s1_vld_r <= sweep_rw;
    end
  end

  always_ff @(posedge clk) begin
    s1_tin_r <= (32'(cnt_r) < 32'(tcc_r));
    s1_pin_r <= (32'(cnt_r) < 32'(pcc_r));
    tprod_r  <= (sweep_on && s1_vld_r && s1_tin_r) ?
                PW'(th_rd_r) * PW'(th_rd_r - CW'(1)) : '0;
    pprod_r  <= (sweep_on && s1_vld_r && s1_pin_r) ?
                PW'(ph_rd_r) * PW'(ph_rd_r - CW'(1)) : '0;
    apair_r  <= (PW'(n_r) * PW'(n_r - CW'(1))) >> 1;
    if (!sweep_on && state_nxt == pcm_pkg::S_SWEEP) begin
      tsum_r <= '0;
      psum_r <= '0;
    end else if (sweep_on) begin
      tsum_r <= tsum_r + (tprod_r >> 1);
      psum_r <= psum_r + (pprod_r >> 1);
    end
  end

  // ratio slots and result
  logic [pcm_pkg::Q_W-1:0]    ratio_r [3];
  logic [pcm_pkg::FLAG_W-1:0] flags_r;
  logic                       out_valid_r;
  pcm_pkg::result_t           out_result_r;

  always_ff @(posedge clk) begin
    if (state_r == pcm_pkg::S_DIV && div_done) begin
      ratio_r[sel_r] <= div_quo;
      flags_r[sel_r] <= div_zero;
    end
    if (state_r == pcm_pkg::S_OUT) begin
      out_result_r.rand_index         <= ratio_r[pcm_pkg::RSEL_RAND];
      out_result_r.precision          <= ratio_r[pcm_pkg::RSEL_PREC];
      out_result_r.recall             <= ratio_r[pcm_pkg::RSEL_REC];
      out_result_r.agree_same_pairs   <= pcm_pkg::PAIR_W'(tp_r);
      out_result_r.agree_diff_pairs   <= pcm_pkg::PAIR_W'(tn_r);
      out_result_r.zero_divisor_flags <= flags_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) out_valid_r <= 1'b0;
    else        out_valid_r <= (state_r == pcm_pkg::S_OUT);
  end

  assign out_valid  = out_valid_r;
  assign out_result = out_result_r;

  a_no_overrun: assert property (@(posedge clk) disable iff (!rst_n) !q_tail.vld)
    else $error("query ran past the last cell");
  a_one_settle: assert property (@(posedge clk) disable iff (!rst_n) $onehot0(settle_v))
    else $error("more than one cell took the sample");
  a_out_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> state_r == pcm_pkg::S_IDLE)
    else $error("result strobe outside idle");
  a_run_walk: assert property (@(posedge clk) disable iff (!rst_n)
    inject |=> state_r == pcm_pkg::S_RUN)
    else $error("accepted sample not walking the chain");
  a_cmp_excl: assert property (@(posedge clk) disable iff (!rst_n) !(same_any && diff_any))
    else $error("pair counted as both agree kinds");

endmodule
